// File: hdl/rrp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the request parser: phase codes, status
// codes, character codes and the result record. No dependencies.
package rrp_pkg;

	localparam int DEF_LEN_BITS = 16;
	localparam int DEF_ARG_BITS = 8;

	typedef enum logic [3:0] {
		PH_WAIT,
		PH_CNT_DIG,
		PH_CNT_LF,
		PH_DOLLAR,
		PH_LEN_DIG,
		PH_LEN_LF,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF
	} phase_t;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  arg_index;
		logic        arg_done;
		logic [15:0] arg_length;
		logic [1:0]  status;
		logic [7:0]  arg_count;
	} result_t;

endpackage

// File: hdl/resp_request_parser_core.sv
`timescale 1ns / 1ps
// Top level of the byte-serial request parser (array of bulk strings).
// Depends on rrp_pkg, rrp_in_stage, rrp_parse and rrp_out_stage.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  input   | in_valid / in_ready    | in_byte
//  output  | out_valid / out_ready  | payload_valid payload_byte arg_index
//          |                        | arg_done arg_length status arg_count
//
// One result beat per input byte beat; one byte per cycle sustained while
// the output is not stalled. Path: byte register, then phase machine into
// the result register.
// Reset (arst_n low) empties both registers and puts the parser in the
// wait-for-asterisk phase with all counters at zero.
// A stalled output holds its beat; the input register still takes a byte
// while the result register is full, and ready drops only when both are full.
module resp_request_parser_core #(
	parameter int LEN_BITS = rrp_pkg::DEF_LEN_BITS,
	parameter int ARG_BITS = rrp_pkg::DEF_ARG_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [7:0]  arg_index,
	output logic        arg_done,
	output logic [15:0] arg_length,
	output logic [1:0]  status,
	output logic [7:0]  arg_count
);
	import rrp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ready_s2;
	logic       step;
	result_t    res_d;
	result_t    res_s2;

	// advance a byte into the parser when the result register has room
	assign step = valid_s1 && ready_s2;

	rrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (ready_s2),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rrp_parse #(
		.LEN_BITS (LEN_BITS),
		.ARG_BITS (ARG_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.res_d   (res_d)
	);

	rrp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res_d     (res_d),
		.ready_s2  (ready_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign arg_index     = res_s2.arg_index;
	assign arg_done      = res_s2.arg_done;
	assign arg_length    = res_s2.arg_length;
	assign status        = res_s2.status;
	assign arg_count     = res_s2.arg_count;

endmodule

// File: hdl/rrp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the request parser: holds one byte beat until the
// parse stage takes it. Depends on nothing.
module rrp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// File: hdl/rrp_parse.sv
`timescale 1ns / 1ps
// Parse stage: phase machine, number accumulator and argument counters,
// one byte per step. Depends on rrp_pkg.
module rrp_parse #(
	parameter int LEN_BITS = rrp_pkg::DEF_LEN_BITS,
	parameter int ARG_BITS = rrp_pkg::DEF_ARG_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	output rrp_pkg::result_t res_d
);
	import rrp_pkg::*;

	localparam int NUM_BITS = (LEN_BITS > ARG_BITS) ? LEN_BITS : ARG_BITS;
	localparam int NW = NUM_BITS + 4;
	localparam logic [NW-1:0] ARG_LIMIT = NW'((64'd1 << ARG_BITS) - 64'd1);
	localparam logic [NW-1:0] LEN_LIMIT = NW'((64'd1 << LEN_BITS) - 64'd1);

	phase_t                phase_q, phase_d;
	logic [NUM_BITS-1:0]   accum_q, accum_d;
	logic [ARG_BITS-1:0]   expected_q, expected_d;
	logic [ARG_BITS-1:0]   seen_q, seen_d;
	logic [LEN_BITS-1:0]   left_q, left_d;
	logic [LEN_BITS-1:0]   curlen_q, curlen_d;

	logic                  is_digit;
	logic [7:0]            digit_full;
	logic [NW-1:0]         acc_ext;
	logic [NW-1:0]         mac;
	logic [NW-1:0]         limit;
	logic [ARG_BITS-1:0]   seen_inc;
	logic [LEN_BITS-1:0]   left_dec;
	logic                  err;
	logic                  complete;
	logic [ARG_BITS+7:0]   seen_wide;
	logic [ARG_BITS+7:0]   expected_wide;
	logic [LEN_BITS+15:0]  curlen_wide;

	assign is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign digit_full = byte_in - CH_ZERO;
	assign acc_ext    = {4'd0, accum_q};
	// times ten as two shifts and an add
	assign mac   = (acc_ext << 3) + (acc_ext << 1) + {{NUM_BITS{1'b0}}, digit_full[3:0]};
	assign limit = (phase_q == PH_CNT_DIG) ? ARG_LIMIT : LEN_LIMIT;
	assign seen_inc = seen_q + 1'b1;
	assign left_dec = left_q - 1'b1;

	assign seen_wide     = {8'd0, seen_q};
	assign expected_wide = {8'd0, expected_q};
	assign curlen_wide   = {16'd0, curlen_q};

	// next state
	always_comb begin
		phase_d    = phase_q;
		accum_d    = accum_q;
		expected_d = expected_q;
		seen_d     = seen_q;
		left_d     = left_q;
		curlen_d   = curlen_q;
		err        = 1'b0;
		complete   = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				if (byte_in == CH_STAR) begin
					accum_d = '0;
					phase_d = PH_CNT_DIG;
				end else begin
					err = 1'b1;
				end
			end
			PH_CNT_DIG, PH_LEN_DIG: begin
				if (is_digit) begin
					accum_d = mac[NUM_BITS-1:0];
					if (mac > limit) err = 1'b1;
				end else if (byte_in == CH_CR) begin
					phase_d = (phase_q == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_CNT_LF: begin
				if (byte_in != CH_LF) begin
					err = 1'b1;
				end else begin
					expected_d = accum_q[ARG_BITS-1:0];
					seen_d     = '0;
					if (accum_q == '0) complete = 1'b1;
					else phase_d = PH_DOLLAR;
				end
			end
			PH_DOLLAR: begin
				if (byte_in == CH_DOLLAR) begin
					accum_d = '0;
					phase_d = PH_LEN_DIG;
				end else begin
					err = 1'b1;
				end
			end
			PH_LEN_LF: begin
				if (byte_in != CH_LF) begin
					err = 1'b1;
				end else begin
					curlen_d = accum_q[LEN_BITS-1:0];
					left_d   = accum_q[LEN_BITS-1:0];
					phase_d  = (accum_q == '0) ? PH_DATA_CR : PH_DATA;
				end
			end
			PH_DATA: begin
				left_d = left_dec;
				if (left_dec == '0) phase_d = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				if (byte_in == CH_CR) phase_d = PH_DATA_LF;
				else err = 1'b1;
			end
			PH_DATA_LF: begin
				if (byte_in != CH_LF) begin
					err = 1'b1;
				end else begin
					seen_d = seen_inc;
					if (seen_inc == expected_q) complete = 1'b1;
					else phase_d = PH_DOLLAR;
				end
			end
			default: err = 1'b1;
		endcase
		// drop back to waiting with all counters cleared
		if (err || complete) begin
			phase_d    = PH_WAIT;
			accum_d    = '0;
			expected_d = '0;
			seen_d     = '0;
			left_d     = '0;
			curlen_d   = '0;
		end
	end

	// result fields
	always_comb begin
		res_d.arg_index     = (phase_q == PH_WAIT) ? 8'd0 : seen_wide[7:0];
		res_d.payload_valid = (phase_q == PH_DATA) && !err;
		res_d.payload_byte  = res_d.payload_valid ? byte_in : 8'd0;
		res_d.arg_done      = (phase_q == PH_DATA_LF) && !err;
		res_d.arg_length    = res_d.arg_done ? curlen_wide[15:0] : 16'd0;
		res_d.arg_count     = (complete && phase_q == PH_DATA_LF) ? expected_wide[7:0] : 8'd0;
		if (err) res_d.status = ST_ERR;
		else if (complete) res_d.status = ST_DONE;
		else res_d.status = ST_BUSY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			accum_q    <= '0;
			expected_q <= '0;
			seen_q     <= '0;
			left_q     <= '0;
			curlen_q   <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			accum_q    <= accum_d;
			expected_q <= expected_d;
			seen_q     <= seen_d;
			left_q     <= left_d;
			curlen_q   <= curlen_d;
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_d.status == ST_DONE |=> phase_q == PH_WAIT && seen_q == '0)
		else $error("parser not idle after request complete");
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_d.status == ST_ERR |=> phase_q == PH_WAIT && accum_q == '0)
		else $error("parser not idle after parse error");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(seen_q) && $stable(left_q))
		else $error("parser state moved without a step");
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("payload phase with no bytes left");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q >= PH_DOLLAR |-> seen_q < expected_q)
		else $error("argument index reached the argument count");
`endif

endmodule

// File: hdl/rrp_out_stage.sv
`timescale 1ns / 1ps
// Result register of the request parser: holds one result beat until the
// consumer takes it. Depends on rrp_pkg.
module rrp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rrp_pkg::result_t res_d,
	output logic             ready_s2,
	output logic             out_valid,
	input  logic             out_ready,
	output rrp_pkg::result_t res_s2
);
	import rrp_pkg::*;

	assign ready_s2 = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s2) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_d;
		end
	end

endmodule
